// ===== design/hfm_pkg.sv =====
// Shared types, constants and functions of the hopping FM waveform generator.
package hfm_pkg;
   localparam logic [31:0] LFSR_SEED = 32'hDEAD0012;
   localparam logic [31:0] LFSR_UNLOCK = 32'h00001337;
   localparam logic [31:0] TONE_BASE = 32'd150000;
   localparam logic [31:0] PHASE_STEP = 32'h01000000;
   localparam logic [31:0] QUARTER_TURN = 32'h40000000;
   localparam logic [31:0] CHIRP_STEP_INT = 32'd167772;
   localparam logic [31:0] CHIRP_STEP_FRAC = 32'd164;

   localparam logic [3:0] MODE_FSK = 4'd0;
   localparam logic [3:0] MODE_TONE = 4'd1;
   localparam logic [3:0] MODE_SWEEP = 4'd2;
   localparam logic [3:0] MODE_RANDOM = 4'd3;
   localparam logic [3:0] MODE_SINE = 4'd4;
   localparam logic [3:0] MODE_SQUARE = 4'd5;
   localparam logic [3:0] MODE_SAW = 4'd6;
   localparam logic [3:0] MODE_TRIANGLE = 4'd7;
   localparam logic [3:0] MODE_CHIRP = 4'd8;
   localparam logic [3:0] MODE_GAUSSIAN = 4'd9;
   localparam logic [3:0] MODE_CONSTANT = 4'd10;

   localparam logic [1:0] CSR_RUN = 2'd0;
   localparam logic [1:0] CSR_MODE = 2'd1;
   localparam logic [1:0] CSR_PERIOD = 2'd2;

   typedef struct packed {
      logic restart;
      logic load;
      logic tick_rd;
      logic search;
      logic hop;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic dwell_zero;
      logic found;
      logic pass_done;
   } status_type;

   function automatic logic [6:0] quarter_sine(input logic [6:0] r);
      logic [6:0] v;
      case (r)
         7'd0: v = 0; 7'd1: v = 3; 7'd2: v = 6; 7'd3: v = 9; 7'd4: v = 12; 7'd5: v = 16;
         7'd6: v = 19; 7'd7: v = 22; 7'd8: v = 25; 7'd9: v = 28; 7'd10: v = 31;
         7'd11: v = 34; 7'd12: v = 37; 7'd13: v = 40; 7'd14: v = 43; 7'd15: v = 46;
         7'd16: v = 49; 7'd17: v = 51; 7'd18: v = 54; 7'd19: v = 57; 7'd20: v = 60;
         7'd21: v = 63; 7'd22: v = 65; 7'd23: v = 68; 7'd24: v = 71; 7'd25: v = 73;
         7'd26: v = 76; 7'd27: v = 78; 7'd28: v = 81; 7'd29: v = 83; 7'd30: v = 85;
         7'd31: v = 88; 7'd32: v = 90; 7'd33: v = 92; 7'd34: v = 94; 7'd35: v = 96;
         7'd36: v = 98; 7'd37: v = 100; 7'd38: v = 102; 7'd39: v = 104; 7'd40: v = 106;
         7'd41: v = 107; 7'd42: v = 109; 7'd43: v = 111; 7'd44: v = 112; 7'd45: v = 113;
         7'd46: v = 115; 7'd47: v = 116; 7'd48: v = 117; 7'd49: v = 118; 7'd50: v = 120;
         7'd51: v = 121; 7'd52: v = 122; 7'd53: v = 122; 7'd54: v = 123; 7'd55: v = 124;
         7'd56: v = 125; 7'd57: v = 125; 7'd58: v = 126; 7'd59: v = 126; 7'd60: v = 126;
         7'd61: v = 127; 7'd62: v = 127; 7'd63: v = 127;
         default: v = 127;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] sine_lookup(input logic [7:0] idx);
      logic [6:0] r;
      logic [6:0] m;
      r = {1'b0, idx[5:0]};
      m = idx[6] ? quarter_sine(7'd64 - r) : quarter_sine(r);
      return idx[7] ? 8'(8'd0 - {1'b0, m}) : {1'b0, m};
   endfunction
endpackage

// ===== design/hfm_ram.sv =====
// Generic single-port-write RAM with a registered read.
module hfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic clock,
   input  logic wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== design/hfm_ctrl.sv =====
// Controller that sequences load, hop search and sample steps for each item.
module hfm_ctrl import hfm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_type,
   input  logic run_enable,
   input  logic run_rise,
   input  logic rsp_busy,
   input  status_type status,
   output cmd_type cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_SEARCH = 3'd2;
   localparam logic [2:0] ST_HOP = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;
   logic take;

   assign req_stall = (state_ff != ST_IDLE) || rsp_busy;
   assign take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.restart = run_rise;
      case (state_ff)
         ST_IDLE: begin
            if (take && !req_type) begin
               cmd.load = 1'b1;
            end else if (take && run_enable) begin
               cmd.tick_rd = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = status.dwell_zero ? ST_SEARCH : ST_FINISH;
         end
         ST_SEARCH: begin
            cmd.search = 1'b1;
            if (status.found) begin
               state_in = ST_HOP;
            end else if (status.pass_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_HOP: begin
            cmd.hop = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== design/hfm_datapath.sv =====
// Channel table, hop search, modulation state and carrier phase datapath.
module hfm_datapath import hfm_pkg::*; #(
   parameter int NUM_CHANNELS = 32
) (
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   output status_type status,
   input  logic [3:0] noise_mode,
   input  logic [31:0] update_period,
   input  logic [4:0] req_entry_index,
   input  logic req_entry_enabled,
   input  logic [31:0] req_entry_dwell,
   input  logic [31:0] req_entry_bandwidth,
   input  logic [31:0] req_entry_center,
   output logic rsp_busy,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [7:0] rsp_i_sample,
   output logic signed [7:0] rsp_q_sample,
   output logic rsp_hop_flag,
   output logic [4:0] rsp_hop_channel,
   output logic [31:0] rsp_hop_center
);
   localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int TW = 95;

   logic [NUM_CHANNELS-1:0] en_ff;
   logic [AW-1:0] cur_ff, cand_ff;
   logic [AW:0] cnt_ff;
   logic [31:0] dwell_ff, half_bw_ff, period_ff, lfsr_ff, wacc_ff, tinc_ff, tph_ff, car_ff;
   logic [7:0] samp_ff, wcnt_ff;
   logic [6:0] chirp_ff;
   logic [31:0] center_ff;
   logic hop_ff;
   logic [31:0] prod_ff;
   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr, next_cand;
   logic [TW-1:0] rd_data;

   function automatic logic [AW-1:0] next_cand_of(input logic [AW-1:0] v);
      return (32'(v) == NUM_CHANNELS - 1) ? '0 : AW'(v + 1'b1);
   endfunction

   assign wr_en = cmd.load && (32'(req_entry_index) < NUM_CHANNELS);
   assign wr_addr = AW'(req_entry_index);
   assign next_cand = next_cand_of(cand_ff);
   assign rd_addr = cmd.search ? cand_ff : cur_ff;

   hfm_ram #(.WIDTH(TW), .DEPTH(NUM_CHANNELS)) u_table (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr),
      .wr_data({req_entry_dwell, req_entry_bandwidth[31:1], req_entry_center}),
      .rd_addr(rd_addr), .rd_data(rd_data));

   logic [31:0] rd_dwell, rd_hbw, rd_center;
   assign rd_dwell = rd_data[TW-1 -: 32];
   assign rd_hbw = {1'b0, rd_data[TW-33 -: 31]};
   assign rd_center = rd_data[TW-64 -: 32];

   // Search looks at the enable of the candidate in the cycle before its row arrives.
   logic cand_en;
   assign cand_en = en_ff[cand_ff];
   assign status.dwell_zero = (dwell_ff == 32'd0);
   assign status.found = cand_en;
   assign status.pass_done = (cnt_ff == (AW + 1)'(NUM_CHANNELS));

   // Next sample-update values.
   logic [31:0] lfsr_step, wacc_in, tinc_in;
   logic [7:0] samp_in, wcnt_in, smp_now;
   logic [6:0] chirp_in;
   logic [31:0] tph_in;
   logic [15:0] saw_prod;
   logic [7:0] saw_div;
   logic [31:0] chirp_add;
   logic do_update;

   assign do_update = (period_ff == 32'd0);

   always_comb begin
      logic fb;
      logic [7:0] c;
      fb = lfsr_ff[31] ^ lfsr_ff[29] ^ lfsr_ff[15] ^ lfsr_ff[11];
      lfsr_step = {lfsr_ff[30:0], fb};
      if (lfsr_step == 32'd0) lfsr_step = LFSR_UNLOCK;
      samp_in = samp_ff;
      wcnt_in = wcnt_ff;
      chirp_in = chirp_ff;
      wacc_in = wacc_ff;
      tinc_in = tinc_ff;
      saw_prod = 16'(8'(wcnt_ff + 8'd1)) * 16'd127;
      saw_div = 8'((32'(saw_prod) * 32'd257 + 32'd257) >> 16);
      chirp_add = 32'd0;
      c = 8'd0;
      case (noise_mode)
         MODE_FSK: samp_in = 8'(({{24{samp_ff[7]}}, samp_ff} + lfsr_ff) >> 1);
         MODE_TONE: tinc_in = TONE_BASE + (lfsr_ff >> 9);
         MODE_SWEEP: samp_in = samp_ff + 8'd1;
         MODE_RANDOM: samp_in = lfsr_ff[7:0];
         MODE_SINE: begin
            wacc_in = wacc_ff + PHASE_STEP;
            samp_in = sine_lookup(wacc_in[31:24]);
         end
         MODE_SQUARE: begin
            wcnt_in = {7'd0, ~wcnt_ff[0]};
            samp_in = wcnt_in[0] ? 8'd127 : 8'h80;
         end
         MODE_SAW: begin
            wcnt_in = wcnt_ff + 8'd1;
            samp_in = saw_div + 8'h80;
         end
         MODE_TRIANGLE: begin
            wcnt_in = wcnt_ff + 8'd1;
            c = wcnt_in[7] ? 8'd255 - wcnt_in : wcnt_in;
            samp_in = c + 8'h80;
         end
         MODE_CHIRP: begin
            chirp_in = (chirp_ff >= 7'd100) ? 7'd0 : chirp_ff + 7'd1;
            // The step over 100 uses 2^24 / 100 as 167772 plus 164 / 1024.
            chirp_add = 32'(chirp_in) * CHIRP_STEP_INT
                        + ((32'(chirp_in) * CHIRP_STEP_FRAC) >> 10);
            wacc_in = wacc_ff + PHASE_STEP + chirp_add;
            samp_in = sine_lookup(wacc_in[31:24]);
         end
         MODE_CONSTANT: samp_in = 8'd127;
         default: ;
      endcase
      if (!do_update) begin
         samp_in = samp_ff;
         wcnt_in = wcnt_ff;
         chirp_in = chirp_ff;
         wacc_in = wacc_ff;
         tinc_in = tinc_ff;
      end
      tph_in = tph_ff;
      smp_now = samp_in;
      if (noise_mode == MODE_TONE) begin
         tph_in = tph_ff + tinc_in;
         smp_now = sine_lookup(tph_in[31:24]);
      end
   end

   logic [7:0] smp_ff;
   logic [31:0] car_next;
   assign car_next = car_ff + prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
         dwell_ff <= '0;
         cur_ff <= '0;
         lfsr_ff <= LFSR_SEED;
         wacc_ff <= '0;
         wcnt_ff <= '0;
         chirp_ff <= '0;
         half_bw_ff <= '0;
         samp_ff <= '0;
         smp_ff <= '0;
         tinc_ff <= '0;
         tph_ff <= '0;
      end else begin
         if (cmd.load && wr_en) begin
            en_ff[wr_addr] <= req_entry_enabled;
         end
         if (cmd.tick_rd) begin
            cand_ff <= next_cand_of(cur_ff);
            cnt_ff <= '0;
            hop_ff <= 1'b0;
         end
         if (cmd.search) begin
            cand_ff <= next_cand;
            cnt_ff <= cnt_ff + 1'b1;
            if (cand_en) begin
               cur_ff <= cand_ff;
            end
         end
         if (cmd.hop) begin
            dwell_ff <= rd_dwell;
            half_bw_ff <= rd_hbw;
            hop_ff <= 1'b1;
         end
         if (cmd.finish) begin
            if (!hop_ff && !status.dwell_zero) dwell_ff <= dwell_ff - 32'd1;
            period_ff <= do_update ? update_period : period_ff - 32'd1;
            if (do_update) lfsr_ff <= lfsr_step;
            samp_ff <= smp_now;
            wcnt_ff <= wcnt_in;
            chirp_ff <= chirp_in;
            wacc_ff <= wacc_in;
            tinc_ff <= tinc_in;
            tph_ff <= tph_in;
            smp_ff <= smp_now;
         end
         prod_ff <= 32'({{24{smp_ff[7]}}, smp_ff} * half_bw_ff);
         if (cmd.restart) begin
            period_ff <= '0;
            dwell_ff <= '0;
            cur_ff <= '0;
            lfsr_ff <= LFSR_SEED;
            wacc_ff <= '0;
            wcnt_ff <= '0;
            chirp_ff <= '0;
         end
      end
   end

   // Output stage: center is taken on pend_ff[0], product and result on pend_ff[1].
   logic [1:0] pend_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         rsp_valid <= 1'b0;
         car_ff <= '0;
      end else begin
         pend_ff <= {pend_ff[0], cmd.finish};
         if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
         if (pend_ff[1]) rsp_valid <= 1'b1;
         if (pend_ff[1]) car_ff <= car_next;
      end
      if (cmd.finish) begin
         center_ff <= 32'd0;
      end
      if (pend_ff[0]) center_ff <= rd_center;
      if (pend_ff[1]) begin
         rsp_i_sample <= sine_lookup(8'((car_next + QUARTER_TURN) >> 24));
         rsp_q_sample <= sine_lookup(car_next[31:24]);
         rsp_hop_flag <= hop_ff;
         rsp_hop_channel <= 5'(cur_ff);
         rsp_hop_center <= center_ff;
      end
   end

   assign rsp_busy = rsp_valid || (pend_ff != 2'b00);
endmodule

// ===== design/hopping_fm_waveform_generator.sv =====
// Top level of the hopping FM waveform generator.
// The req channel carries load items (req_type 0) that write one channel table
// entry, and tick items (req_type 1) that produce one IQ result on rsp while
// running. Loads give no result. A tick passes the READ and FINISH states and
// the pend_ff registers before its result is valid, and the next item is taken
// only after the result is taken; when the dwell count has run out, the hop
// search runs before FINISH, one table entry a cycle.
// The result path (table read, product register, phase register) must drain
// before the next item is taken, so the next tick starts once the result is taken.
// Registers are written on the csr channel: 0 run_enable, 1 noise_mode,
// 2 update_period; a rising write of run_enable restarts counters and the LFSR.
// Reset clears all control state; the channel table is undefined until loaded.
// While rsp_stall is high the result holds and req_stall stays high.
module hopping_fm_waveform_generator import hfm_pkg::*; #(
   parameter int NUM_CHANNELS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_type,
   input  logic [4:0] req_entry_index,
   input  logic req_entry_enabled,
   input  logic [31:0] req_entry_dwell,
   input  logic [31:0] req_entry_bandwidth,
   input  logic [31:0] req_entry_center,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [7:0] rsp_i_sample,
   output logic signed [7:0] rsp_q_sample,
   output logic rsp_hop_flag,
   output logic [4:0] rsp_hop_channel,
   output logic [31:0] rsp_hop_center,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data
);
   logic run_ff;
   logic [3:0] mode_ff;
   logic [31:0] period_ff;
   logic run_rise, rsp_busy, csr_wr;
   cmd_type cmd;
   status_type status;

   assign csr_ready = 1'b1;
   assign csr_wr = csr_valid;
   assign run_rise = csr_wr && (csr_index == CSR_RUN) && csr_data[0] && !run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         mode_ff <= '0;
         period_ff <= '0;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_RUN: run_ff <= csr_data[0];
            CSR_MODE: mode_ff <= csr_data[3:0];
            CSR_PERIOD: period_ff <= csr_data;
            default: ;
         endcase
      end
   end

   hfm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_type(req_type), .run_enable(run_ff), .run_rise(run_rise),
      .rsp_busy(rsp_busy), .status(status), .cmd(cmd));

   hfm_datapath #(.NUM_CHANNELS(NUM_CHANNELS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .noise_mode(mode_ff), .update_period(period_ff),
      .req_entry_index(req_entry_index), .req_entry_enabled(req_entry_enabled),
      .req_entry_dwell(req_entry_dwell), .req_entry_bandwidth(req_entry_bandwidth),
      .req_entry_center(req_entry_center), .rsp_busy(rsp_busy),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_i_sample(rsp_i_sample), .rsp_q_sample(rsp_q_sample),
      .rsp_hop_flag(rsp_hop_flag), .rsp_hop_channel(rsp_hop_channel),
      .rsp_hop_center(rsp_hop_center));
endmodule
